// ===== hw/rtl/nalt_pkg.sv =====
// Shared types, constants and codes for the node address lease table.
package nalt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int EMIT_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int TTL_W         = 8;
  localparam logic [TTL_W-1:0] TTL_RESET = 8'd3;

  localparam logic [2:0] OP_REGISTER  = 3'd0;
  localparam logic [2:0] OP_TICK      = 3'd1;
  localparam logic [2:0] OP_HEARTBEAT = 3'd2;
  localparam logic [2:0] OP_KEY       = 3'd3;
  localparam logic [2:0] OP_LIST      = 3'd4;

  localparam logic [1:0] KIND_ASSIGNED = 2'd0;
  localparam logic [1:0] KIND_DEAD     = 2'd1;
  localparam logic [1:0] KIND_ALIVE    = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] node_addr;
    logic [7:0] key_value;
  } nalt_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] result_addr;
    logic [4:0] alive_total;
    logic       last;
  } nalt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_TICK,
    ST_LIST,
    ST_FLUSH
  } nalt_state_t;

  typedef struct packed {
    logic load;
    logic hb;
    logic key;
    logic step_reg;
    logic step_tick;
    logic step_list;
    logic flush;
  } nalt_cmd_t;

  typedef struct packed {
    logic step_ok;
    logic last_slot;
    logic found;
    logic flush_ok;
  } nalt_sts_t;

endpackage

// ===== hw/rtl/nalt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module nalt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/nalt_ctrl.sv =====
// Controller state machine sequencing the slot scans.
module nalt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_opcode,
  output logic                in_ready,
  input  nalt_pkg::nalt_sts_t sts,
  output nalt_pkg::nalt_cmd_t cmd
);

  nalt_pkg::nalt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nalt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      nalt_pkg::ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load = 1'b1;
          unique case (in_opcode)
            nalt_pkg::OP_REGISTER:  state_nxt = nalt_pkg::ST_REG;
            nalt_pkg::OP_TICK:      state_nxt = nalt_pkg::ST_TICK;
            nalt_pkg::OP_LIST:      state_nxt = nalt_pkg::ST_LIST;
            nalt_pkg::OP_HEARTBEAT: cmd.hb = 1'b1;
            nalt_pkg::OP_KEY:       cmd.key = 1'b1;
            default:                state_nxt = nalt_pkg::ST_IDLE;
          endcase
        end
      end
      nalt_pkg::ST_REG: begin
        cmd.step_reg = 1'b1;
        if (sts.step_ok && (sts.found || sts.last_slot)) begin
          state_nxt = nalt_pkg::ST_FLUSH;
        end
      end
      nalt_pkg::ST_TICK: begin
        cmd.step_tick = 1'b1;
        if (sts.step_ok && sts.last_slot) begin
          state_nxt = nalt_pkg::ST_FLUSH;
        end
      end
      nalt_pkg::ST_LIST: begin
        cmd.step_list = 1'b1;
        if (sts.step_ok && sts.last_slot) begin
          state_nxt = nalt_pkg::ST_FLUSH;
        end
      end
      nalt_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.flush_ok) begin
          state_nxt = nalt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nalt_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/nalt_datapath.sv =====
// Slot flags, TTL memory, alive count, pending result and output register.
module nalt_datapath #(
  parameter int NUM_SLOTS = nalt_pkg::NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nalt_pkg::nalt_cmd_t  cmd,
  output nalt_pkg::nalt_sts_t  sts,
  input  nalt_pkg::nalt_in_t   in_word,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nalt_pkg::nalt_out_t  out_word
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int ECW    = nalt_pkg::EMIT_CNT_W;
  localparam int TW     = nalt_pkg::TTL_W;

  // key bytes never reach a result, so only TTL and used flags are held
  logic [TW-1:0]        ttl_start_r, ttl_start_nxt;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]     alive_cnt_r, alive_cnt_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  nalt_pkg::nalt_out_t  pend_word_r, pend_word_nxt;
  logic [ECW-1:0]       em_cnt_r, em_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  nalt_pkg::nalt_out_t  out_word_r, out_word_nxt;

  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [TW-1:0]        ram_wdata;
  logic [TW-1:0]        ttl_rdata;

  logic [8:0]           slot_addr9;
  logic [8:0]           total9;
  logic [7:0]           addr_m1;
  logic [SLOT_W-1:0]    hb_idx;
  logic                 addr_ok;
  logic                 cur_used;
  logic                 last_slot;
  logic                 ttl_zero;
  logic                 emit_req;
  logic                 emit_keep;
  logic                 out_free;
  logic                 stepping;
  logic                 step_ok;
  logic                 go;
  logic                 push_mid;
  logic                 push_fin;
  nalt_pkg::nalt_out_t  new_word;

  nalt_ram #(
    .WIDTH(TW),
    .DEPTH(NUM_SLOTS)
  ) u_ttl_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_nxt),
    .rdata(ttl_rdata)
  );

  always_comb begin
    slot_addr9 = 9'(idx_r) + 9'd1;
    total9     = 9'(alive_cnt_r);
    addr_m1    = in_word.node_addr - 8'd1;
    hb_idx     = addr_m1[SLOT_W-1:0];
    addr_ok    = (in_word.node_addr != 8'd0) && ({1'b0, in_word.node_addr} <= 9'(NUM_SLOTS));
    cur_used   = used_r[idx_r];
    last_slot  = (idx_r == SLOT_W'(NUM_SLOTS - 1));
    ttl_zero   = (ttl_rdata == '0);

    emit_req = 1'b0;
    new_word = '0;
    if (cmd.step_reg) begin
      emit_req         = !cur_used || last_slot;
      new_word.kind    = nalt_pkg::KIND_ASSIGNED;
      new_word.result_addr = cur_used ? 5'd0 : slot_addr9[4:0];
    end else if (cmd.step_tick) begin
      emit_req         = cur_used && ttl_zero;
      new_word.kind    = nalt_pkg::KIND_DEAD;
      new_word.result_addr = slot_addr9[4:0];
    end else if (cmd.step_list) begin
      emit_req         = cur_used;
      new_word.kind    = nalt_pkg::KIND_ALIVE;
      new_word.result_addr = slot_addr9[4:0];
      new_word.alive_total = total9[4:0];
    end

    emit_keep = emit_req && (em_cnt_r < ECW'(nalt_pkg::MAX_RESULTS));
    out_free  = !out_valid_r || out_ready;
    stepping  = cmd.step_reg || cmd.step_tick || cmd.step_list;
    step_ok   = !(emit_keep && pend_valid_r) || out_free;
    go        = stepping && step_ok;
    push_mid  = go && emit_keep && pend_valid_r;
    push_fin  = cmd.flush && pend_valid_r && out_free;

    sts.step_ok   = step_ok;
    sts.last_slot = last_slot;
    sts.found     = !cur_used;
    sts.flush_ok  = !pend_valid_r || out_free;

    ttl_start_nxt  = cfg_we ? cfg_wdata : ttl_start_r;
    used_nxt       = used_r;
    alive_cnt_nxt  = alive_cnt_r;
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_word_nxt  = pend_word_r;
    em_cnt_nxt     = em_cnt_r;
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = ttl_start_r;

    if (cmd.load) begin
      idx_nxt        = '0;
      pend_valid_nxt = 1'b0;
      em_cnt_nxt     = '0;
    end

    if (cmd.hb && addr_ok && used_r[hb_idx]) begin
      ram_we    = 1'b1;
      ram_waddr = hb_idx;
    end
    if (cmd.key && addr_ok) begin
      ram_we    = 1'b1;
      ram_waddr = hb_idx;
    end

    if (go) begin
      if (!last_slot) begin
        idx_nxt = idx_r + SLOT_W'(1);
      end
      if (cmd.step_reg && !cur_used) begin
        used_nxt[idx_r] = 1'b1;
        alive_cnt_nxt   = alive_cnt_r + CNT_W'(1);
        ram_we          = 1'b1;
      end
      if (cmd.step_tick && cur_used) begin
        if (ttl_zero) begin
          used_nxt[idx_r] = 1'b0;
          alive_cnt_nxt   = alive_cnt_r - CNT_W'(1);
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ttl_rdata - TW'(1);
        end
      end
      if (emit_keep) begin
        pend_valid_nxt = 1'b1;
        pend_word_nxt  = new_word;
        em_cnt_nxt     = em_cnt_r + ECW'(1);
      end
    end

    if (push_mid) begin
      out_valid_nxt     = 1'b1;
      out_word_nxt      = pend_word_r;
      out_word_nxt.last = 1'b0;
    end
    if (push_fin) begin
      out_valid_nxt     = 1'b1;
      out_word_nxt      = pend_word_r;
      out_word_nxt.last = 1'b1;
      pend_valid_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_start_r  <= nalt_pkg::TTL_RESET;
      used_r       <= '0;
      alive_cnt_r  <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      em_cnt_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      ttl_start_r  <= ttl_start_nxt;
      used_r       <= used_nxt;
      alive_cnt_r  <= alive_cnt_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      em_cnt_r     <= em_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_word_r <= pend_word_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_alive_count: assert property (@(posedge clk) disable iff (!rst_n)
    alive_cnt_r == CNT_W'($countones(used_r)))
    else $error("alive count out of step with used flags");

  a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    em_cnt_r <= ECW'(nalt_pkg::MAX_RESULTS))
    else $error("result count beyond cap");

  a_final_word: assert property (@(posedge clk) disable iff (!rst_n)
    push_fin |=> (!pend_valid_r && out_valid_r && out_word_r.last))
    else $error("final word not presented or pending word left");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (!pend_valid_r && (em_cnt_r == '0)))
    else $error("pending state not cleared on new word");
`endif

endmodule

// ===== hw/rtl/node_address_lease_table.sv =====
// Top level of the node address lease table.
//
//   port group   direction  handshake           payload
//   in_*         input      in_valid/in_ready   nalt_in_t  (opcode, node_addr, key_value)
//   out_*        output     out_valid/out_ready nalt_out_t (kind, result_addr, alive_total, last)
//   cfg_*        input      cfg_we              cfg_wdata  (ttl_start)
//
// Heartbeat, key and unknown words are handled in the idle state. Tick and list scan every
// slot, register up to the first free one, one slot per cycle through the TTL RAM port.
// The result register only delays the scan when it is still full on the next result.
// Synchronous reset clears the used flags at once; TTL memory needs no clearing pass.
module node_address_lease_table #(
  parameter int NUM_SLOTS = nalt_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nalt_pkg::nalt_in_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output nalt_pkg::nalt_out_t out_word,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  nalt_pkg::nalt_cmd_t cmd;
  nalt_pkg::nalt_sts_t sts;

  nalt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_word.opcode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nalt_datapath #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_word  (in_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule

// ===== bench/tb_node_address_lease_table.sv =====
// Self-checking bench for the node address lease table: lease predictor, random traffic, stalls.
module tb_node_address_lease_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = nalt_pkg::NUM_SLOTS_DEF;
  localparam int LIMIT = 600000;
  localparam int SETTLE = NSLOT * 2 + 8;

  class lease_book;
    logic [7:0]          ttl_start;
    bit                  used [NSLOT];
    logic [7:0]          key  [NSLOT];
    logic [7:0]          ttl  [NSLOT];
    nalt_pkg::nalt_out_t due [$];
    int                  errors;

    function new();
      ttl_start = nalt_pkg::TTL_RESET;
      errors = 0;
      for (int i = 0; i < NSLOT; i++) begin
        used[i] = 1'b0;
        key[i] = '0;
        ttl[i] = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    function nalt_pkg::nalt_out_t result_of(logic [1:0] kind, logic [4:0] addr,
                                            logic [4:0] total);
      nalt_pkg::nalt_out_t r;
      r.kind = kind;
      r.result_addr = addr;
      r.alive_total = total;
      r.last = 1'b0;
      return r;
    endfunction

    function void note_word(nalt_pkg::nalt_in_t w);
      nalt_pkg::nalt_out_t batch [$];
      nalt_pkg::nalt_out_t r;
      logic [4:0]          got;
      int                  a;
      int                  total;
      int                  n;
      got = '0;
      total = 0;
      a = int'(w.node_addr);
      case (w.opcode)
        nalt_pkg::OP_REGISTER: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (!used[i]) begin
              used[i] = 1'b1;
              ttl[i] = ttl_start;
              got = 5'(i + 1);
              break;
            end
          end
          batch.push_back(result_of(nalt_pkg::KIND_ASSIGNED, got, 5'd0));
        end
        nalt_pkg::OP_TICK: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (used[i]) begin
              if (ttl[i] == 8'd0) begin
                used[i] = 1'b0;
                key[i] = '0;
                batch.push_back(result_of(nalt_pkg::KIND_DEAD, 5'(i + 1), 5'd0));
              end else begin
                ttl[i] = ttl[i] - 8'd1;
              end
            end
          end
        end
        nalt_pkg::OP_HEARTBEAT: begin
          if (a >= 1 && a <= NSLOT && used[a-1]) begin
            ttl[a-1] = ttl_start;
          end
        end
        nalt_pkg::OP_KEY: begin
          if (a >= 1 && a <= NSLOT) begin
            key[a-1] = w.key_value;
            ttl[a-1] = ttl_start;
          end
        end
        nalt_pkg::OP_LIST: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (used[i]) begin
              total++;
            end
          end
          for (int i = 0; i < NSLOT; i++) begin
            if (used[i]) begin
              batch.push_back(result_of(nalt_pkg::KIND_ALIVE, 5'(i + 1), 5'(total)));
            end
          end
        end
        default: ;
      endcase
      n = (batch.size() > nalt_pkg::MAX_RESULTS) ? nalt_pkg::MAX_RESULTS : batch.size();
      for (int k = 0; k < n; k++) begin
        r = batch[k];
        r.last = (k == n - 1);
        due.push_back(r);
      end
    endfunction

    task check_word(nalt_pkg::nalt_out_t got);
      nalt_pkg::nalt_out_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected word kind=%0d addr=%0d total=%0d last=%0b",
                         got.kind, got.result_addr, got.alive_total, got.last));
        return;
      end
      want = due.pop_front();
      if (got.kind != want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.result_addr != want.result_addr)
        report($sformatf("result_addr %0d, want %0d", got.result_addr, want.result_addr));
      if (got.alive_total != want.alive_total)
        report($sformatf("alive_total %0d, want %0d", got.alive_total, want.alive_total));
      if (got.last != want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  nalt_pkg::nalt_in_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  nalt_pkg::nalt_out_t out_word;
  logic                cfg_we = 1'b0;
  logic [7:0]          cfg_wdata = '0;

  lease_book book;
  int        cycles = 0;
  int        rx_cnt = 0;
  rx_mode_t  rx_mode = RX_OPEN;

  node_address_lease_table #(.NUM_SLOTS(NSLOT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        book.note_word(in_word);
      end
      if (out_valid && out_ready) begin
        book.check_word(out_word);
      end
    end
  end

  // receiver back-pressure; the mode is redrawn at random from four modes
  always @(negedge clk) begin
    rx_cnt++;
    if (rx_cnt % 50 == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3));
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(1));
      RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
      default:   out_ready <= (rx_cnt % 8 < 5);
    endcase
  end

  function automatic nalt_pkg::nalt_in_t word_of(logic [2:0] op, logic [7:0] a,
                                                 logic [7:0] k);
    nalt_pkg::nalt_in_t w;
    w.opcode = op;
    w.node_addr = a;
    w.key_value = k;
    return w;
  endfunction

  function automatic nalt_pkg::nalt_in_t rand_word(int reg_w);
    nalt_pkg::nalt_in_t w;
    int                 pick;
    w.node_addr = 8'($urandom_range(255));
    w.key_value = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < reg_w) begin
      w.opcode = nalt_pkg::OP_REGISTER;
    end else begin
      pick = $urandom_range(99);
      if (pick < 30)      w.opcode = nalt_pkg::OP_TICK;
      else if (pick < 58) w.opcode = nalt_pkg::OP_HEARTBEAT;
      else if (pick < 72) w.opcode = nalt_pkg::OP_KEY;
      else if (pick < 93) w.opcode = nalt_pkg::OP_LIST;
      else                w.opcode = 3'($urandom_range(int'(nalt_pkg::OP_LIST) + 1, 7));
    end
    if ((w.opcode == nalt_pkg::OP_HEARTBEAT || w.opcode == nalt_pkg::OP_KEY) &&
        $urandom_range(9) != 0) begin
      w.node_addr = 8'($urandom_range(1, NSLOT));
    end
    return w;
  endfunction

  task send_word(nalt_pkg::nalt_in_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task pause(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
  endtask

  task set_ttl(logic [7:0] v);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    book.ttl_start = v;
  endtask

  task run_phase(int reg_w, bit gaps, int target);
    nalt_pkg::nalt_in_t w;
    int                 counted;
    int                 burst;
    counted = 0;
    burst = $urandom_range(1, 12);
    while (counted < target) begin
      w = rand_word(reg_w);
      send_word(w);
      if (w.opcode <= nalt_pkg::OP_LIST) counted++;
      burst--;
      if ($urandom_range(39) == 0) begin
        drain_results();
      end else if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if (gaps) pause($urandom_range(0, 6));
      end
    end
  endtask

  initial begin
    logic [7:0] ttl_plan [5];
    int         reg_plan [5];
    book = new();
    ttl_plan = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(2, 12)), 8'd2};
    reg_plan = '{35, 30, 60, 30, 35};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(word_of(nalt_pkg::OP_LIST, 8'd0, 8'd0));
    send_word(word_of(nalt_pkg::OP_TICK, 8'hFF, 8'hFF));
    send_word(word_of(nalt_pkg::OP_HEARTBEAT, 8'd0, 8'd0));
    send_word(word_of(nalt_pkg::OP_KEY, 8'(NSLOT + 1), 8'hFF));
    send_word(word_of(3'd7, 8'hFF, 8'h00));
    // fill the table, then one more register to hit the full case
    repeat (NSLOT + 1) send_word(word_of(nalt_pkg::OP_REGISTER, 8'($urandom_range(255)),
                                         8'($urandom_range(255))));
    send_word(word_of(nalt_pkg::OP_LIST, 8'd0, 8'd0));
    send_word(word_of(nalt_pkg::OP_TICK, 8'd0, 8'd0));
    send_word(word_of(nalt_pkg::OP_HEARTBEAT, 8'(NSLOT), 8'd0));
    send_word(word_of(nalt_pkg::OP_KEY, 8'd1, 8'hA5));
    repeat (3) send_word(word_of(nalt_pkg::OP_TICK, 8'd0, 8'd0));

    for (int p = 0; p < 5; p++) begin
      set_ttl(ttl_plan[p]);
      run_phase(reg_plan[p], (p != 2), 73);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (book.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/nalt_pkg.sv
hw/rtl/nalt_ram.sv
hw/rtl/nalt_ctrl.sv
hw/rtl/nalt_datapath.sv
hw/rtl/node_address_lease_table.sv
bench/tb_node_address_lease_table.sv
